### sv/lstf_pkg.sv
// lstf_pkg: shared types, constants and functions for the lcd serial text framer
// no dependencies

package lstf_pkg;

    localparam int FRAME_BITS = 24;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS);

    localparam logic [7:0] SYNC_CMD = 8'hF8;
    localparam logic [7:0] SYNC_DAT = 8'hFA;

    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_POS  = 2'd2;
    localparam logic [1:0] FUNC_CHAR = 2'd3;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_val;
        logic       last;
    } frame_req_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'h90;
            2'd2:    base = 8'h88;
            2'd3:    base = 8'h98;
            default: base = 8'h80;
        endcase
        return base;
    endfunction

    function automatic logic [FRAME_BITS-1:0] build_frame(input logic is_data,
                                                         input logic [7:0] byte_val);
        return {(is_data ? SYNC_DAT : SYNC_CMD), byte_val[7:4], 4'b0000,
                byte_val[3:0], 4'b0000};
    endfunction

endpackage

### sv/lstf_if.sv
// lstf_in_if / lstf_out_if: valid/ready channels for the framer
// no dependencies

interface lstf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] value;
    logic [1:0] row;
    logic [2:0] column;

    modport source (output valid, func, value, row, column, input ready);
    modport sink   (input valid, func, value, row, column, output ready);
endinterface

interface lstf_out_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic frame_end;
    logic last;

    modport source (output valid, serial_bit, frame_end, last, input ready);
    modport sink   (input valid, serial_bit, frame_end, last, output ready);
endinterface

### sv/lstf_ctrl.sv
// lstf_ctrl: decodes input items, keeps text position state, issues frame requests
// depends on lstf_pkg and lstf_if

module lstf_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    lstf_in_if.sink             in_ch,
    output logic                req_valid,
    output lstf_pkg::frame_req_t req,
    input  logic                req_take
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_FIRST  = 3'b010,
        S_SECOND = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  start_row_reg, start_row_next;
    logic [2:0]  start_col_reg, start_col_next;
    logic [7:0]  char_count_reg, char_count_next;
    logic        first_data_reg, first_data_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic        second_reg, second_next;
    logic [7:0]  second_byte_reg, second_byte_next;

    logic       accept;
    logic [7:0] count_inc;
    logic [8:0] cell_sum;
    logic [4:0] quot;
    logic       wrap_hit;

    assign accept    = in_ch.valid && in_ch.ready;
    assign count_inc = char_count_reg + 8'd1;
    assign cell_sum  = {1'b0, count_inc} + {5'b00000, start_col_reg, 1'b0};
    assign quot      = cell_sum[8:4];
    assign wrap_hit  = (cell_sum[3:0] == 4'd0) && (quot >= 5'd1) && (quot <= 5'd4);

    always_comb
    begin
        state_next       = state_reg;
        start_row_next   = start_row_reg;
        start_col_next   = start_col_reg;
        char_count_next  = char_count_reg;
        first_data_next  = first_data_reg;
        first_byte_next  = first_byte_reg;
        second_next      = second_reg;
        second_byte_next = second_byte_reg;
        in_ch.ready      = 1'b0;
        req_valid        = 1'b0;
        req.is_data      = first_data_reg;
        req.byte_val     = first_byte_reg;
        req.last         = !second_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next       = S_FIRST;
                    second_next      = 1'b0;
                    first_byte_next  = in_ch.value;
                    second_byte_next = lstf_pkg::row_base(start_row_reg + quot[1:0]);
                    case (in_ch.func)
                        lstf_pkg::FUNC_CMD:
                            first_data_next = 1'b0;
                        lstf_pkg::FUNC_DATA:
                            first_data_next = 1'b1;
                        lstf_pkg::FUNC_POS:
                        begin
                            first_data_next = 1'b0;
                            first_byte_next = lstf_pkg::row_base(in_ch.row)
                                              + {5'b00000, in_ch.column};
                            start_row_next  = in_ch.row;
                            start_col_next  = in_ch.column;
                            char_count_next = 8'd0;
                        end
                        default:
                        begin
                            first_data_next = 1'b1;
                            char_count_next = count_inc;
                            second_next     = wrap_hit;
                        end
                    endcase
                end
            end
            S_FIRST:
            begin
                req_valid = 1'b1;
                if (req_take)
                    state_next = second_reg ? S_SECOND : S_IDLE;
            end
            S_SECOND:
            begin
                req_valid    = 1'b1;
                req.is_data  = 1'b0;
                req.byte_val = second_byte_reg;
                req.last     = 1'b1;
                if (req_take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_row_reg  <= 2'd0;
            start_col_reg  <= 3'd0;
            char_count_reg <= 8'd0;
            second_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_row_reg  <= start_row_next;
            start_col_reg  <= start_col_next;
            char_count_reg <= char_count_next;
            second_reg     <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_data_reg  <= first_data_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
        end
    end

endmodule

### sv/lstf_shift.sv
// lstf_shift: 24-bit frame shift register, one serial bit per output item
// depends on lstf_pkg and lstf_if

module lstf_shift
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  lstf_pkg::frame_req_t req,
    output logic                 req_take,
    lstf_out_if.source           out_ch
);

    logic [lstf_pkg::FRAME_BITS-1:0] shift_reg, shift_next;
    logic [lstf_pkg::BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            last_reg, last_next;
    logic                            out_take;
    logic                            at_end;

    assign out_take = out_ch.valid && out_ch.ready;
    assign at_end   = (cnt_reg == lstf_pkg::LAST_BIT);
    assign req_take = req_valid && (!busy_reg || (out_take && at_end));

    assign out_ch.valid      = busy_reg;
    assign out_ch.serial_bit = shift_reg[lstf_pkg::FRAME_BITS-1];
    assign out_ch.frame_end  = at_end;
    assign out_ch.last       = at_end && last_reg;

    always_comb
    begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        if (out_take)
        begin
            shift_next = {shift_reg[lstf_pkg::FRAME_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + {{(lstf_pkg::BIT_CNT_W-1){1'b0}}, 1'b1};
            if (at_end)
                busy_next = 1'b0;
        end
        if (req_take)
        begin
            shift_next = lstf_pkg::build_frame(req.is_data, req.byte_val);
            cnt_next   = '0;
            busy_next  = 1'b1;
            last_next  = req.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        last_reg  <= last_next;
    end

endmodule

### sv/lcd_serial_text_framer_core.sv
// Serial text framer for a 128x64 character LCD controller. Each input item
// produces one or two 24-bit frames (sync byte, high nibble, low nibble), sent
// msb first as one output item per bit, so an item yields 24 or 48 output items.
// With the output always ready the shift register sends frames back to back;
// the next input item is taken once the last frame of the previous one has been
// loaded, so a new item can be accepted while that frame is still shifting out.
// Depends on lstf_pkg, lstf_if, lstf_ctrl and lstf_shift.

module lcd_serial_text_framer_core
(
    input  logic        clk,
    input  logic        rst_n,
    lstf_in_if.sink     in_ch,
    lstf_out_if.source  out_ch
);

    logic                 req_valid;
    logic                 req_take;
    lstf_pkg::frame_req_t req;

    lstf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    lstf_shift u_shift
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .out_ch    (out_ch)
    );

endmodule
